// File: hw/rtl/sit_pkg.sv
// sit_pkg: shared constants and types for the sorted id table.
// Opcodes, status codes, field widths and the cell update command.
// No dependencies.
`default_nettype none

package sit_pkg;

  // default sizes
  localparam int CAPACITY_DEF  = 256;
  localparam int TAIL_BITS_DEF = 32;

  // field widths
  localparam int ID_W       = 32;
  localparam int TAIL_IN_W  = 32;
  localparam int REC_W      = 32;
  localparam int OPC_W      = 2;
  localparam int STAT_W     = 2;
  localparam int POS_W      = 9;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;

  // opcodes
  localparam logic [OPC_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OPC_W-1:0] OP_GET   = 2'd1;
  localparam logic [OPC_W-1:0] OP_DEL   = 2'd2;
  localparam logic [OPC_W-1:0] OP_FIRST = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  // what every cell of the chain does on an update edge
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/sit_cell.sv
// sit_cell: one table slot of the chain; holds id, tail and record.
// Compares against the broadcast key and shifts with its neighbors.
// Depends on sit_pkg.
`default_nettype none

module sit_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 9,
  parameter int IW    = 8,
  parameter int TW    = 32
) (
  input  wire                           clk,
  input  sit_pkg::cell_cmd_t            cmd,
  input  wire [IW-1:0]                  pos,
  input  wire [CW-1:0]                  count,
  input  wire                           ext,
  input  wire [sit_pkg::ID_W-1:0]       key_id,
  input  wire [TW-1:0]                  key_tail,
  input  wire [sit_pkg::REC_W-1:0]      new_rec,
  input  wire [sit_pkg::ID_W-1:0]       left_id,
  input  wire [TW-1:0]                  left_tail,
  input  wire [sit_pkg::REC_W-1:0]      left_rec,
  input  wire [sit_pkg::ID_W-1:0]       right_id,
  input  wire [TW-1:0]                  right_tail,
  input  wire [sit_pkg::REC_W-1:0]      right_rec,
  output logic [sit_pkg::ID_W-1:0]      id,
  output logic [TW-1:0]                 tail,
  output logic [sit_pkg::REC_W-1:0]     rec,
  output logic                          le,
  output logic                          hit
);

  localparam logic [IW-1:0] IDX = IW'(INDEX);

  logic valid;
  logic eq;
  logic left_eq;
  logic at_pos;
  logic past_pos;

  assign valid    = count > CW'(INDEX);
  assign eq       = valid && (id == key_id);
  assign le       = valid && (id <= key_id);
  // first entry of an equal-id run: left neighbor differs (or there is none)
  assign left_eq  = (INDEX != 0) && (left_id == key_id);
  assign hit      = ext ? (eq && (tail == key_tail)) : (eq && !left_eq);
  assign at_pos   = IDX == pos;
  assign past_pos = IDX > pos;

  always_ff @(posedge clk) begin
    case (cmd)
      sit_pkg::CMD_INSERT: begin
        if (at_pos) begin
          id   <= key_id;
          tail <= key_tail;
          rec  <= new_rec;
        end else if (past_pos) begin
          id   <= left_id;
          tail <= left_tail;
          rec  <= left_rec;
        end
      end
      sit_pkg::CMD_DELETE: begin
        if (at_pos || past_pos) begin
          id   <= right_id;
          tail <= right_tail;
          rec  <= right_rec;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sit_fold.sv
// sit_fold: registered OR-reduction tree, one level per cycle while step is high.
// Collapses the per-cell hit words of the chain into one result word.
// Depends on nothing.
`default_nettype none

module sit_fold #(
  parameter int LEAVES = 256,
  parameter int W      = 41
) (
  input  wire          clk,
  input  wire          load,
  input  wire          step,
  input  wire [W-1:0]  leaf [LEAVES],
  output logic [W-1:0] result
);

  localparam int H = LEAVES / 2;

  logic [W-1:0] acc [H];

  genvar i;
  generate
    for (i = 0; i < H; i++) begin : g_node
      if (2 * i + 1 < H) begin : g_pair
        always_ff @(posedge clk) begin
          if (load) begin
            acc[i] <= leaf[2*i] | leaf[2*i+1];
          end else if (step) begin
            acc[i] <= acc[2*i] | acc[2*i+1];
          end
        end
      end else begin : g_tail
        always_ff @(posedge clk) begin
          if (load) begin
            acc[i] <= leaf[2*i] | leaf[2*i+1];
          end else if (step) begin
            acc[i] <= '0;
          end
        end
      end
    end
  endgenerate

  assign result = acc[0];

endmodule

`default_nettype wire

// File: hw/rtl/sorted_id_table_top.sv
// sorted_id_table_top: table of up to CAPACITY entries sorted by id, held in a chain of cells.
// A transaction passes ST_CMP, then ST_SEARCH until the upper-bound binary search and the
//   hit tree are both done, then ST_FINISH until the result register is free.
// Throughput: one transaction at a time; the next is taken the cycle after the result is
//   registered.
// Reset (rst, synchronous): table empty, extended_key 0; entry contents are not cleared.
// Depends on sit_pkg, sit_cell, sit_fold.
`default_nettype none

module sorted_id_table_top #(
  parameter int CAPACITY  = sit_pkg::CAPACITY_DEF,
  parameter int TAIL_BITS = sit_pkg::TAIL_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // input channel
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: key_id [31:0], key_tail [63:32], record_in [95:64]
  input  wire [sit_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: opcode [1:0]
  input  wire [sit_pkg::OPC_W-1:0]         s_axis_tuser,
  // result channel
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tdata: record_out [31:0], position [40:32], entry_count [49:41], zero [55:50]
  output logic [sit_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: status [1:0]
  output logic [sit_pkg::STAT_W-1:0]       m_axis_tuser,
  // extended_key register
  input  wire                              cfg_wr_en,
  input  wire                              cfg_wr_data
);

  localparam int IW   = $clog2(CAPACITY);          // cell index bits
  localparam int CW   = $clog2(CAPACITY + 1);      // count / position bits
  localparam int P    = 1 << IW;                   // tree leaves, padded
  localparam int TW   = (TAIL_BITS < sit_pkg::TAIL_IN_W) ? TAIL_BITS : sit_pkg::TAIL_IN_W;
  localparam int LW   = 1 + IW + sit_pkg::REC_W;   // hit word: {hit, index, record}
  localparam int FCW  = $clog2(IW + 1);
  localparam int PADW = sit_pkg::OUT_DATA_W - sit_pkg::REC_W - 2 * sit_pkg::POS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state;

  // control
  logic          ext;
  logic [CW-1:0] count;

  // latched transaction
  logic [sit_pkg::OPC_W-1:0] op_q;
  logic [sit_pkg::ID_W-1:0]  key_id_q;
  logic [TW-1:0]             key_tail_q;
  logic [sit_pkg::REC_W-1:0] rec_q;

  // search
  logic [CAPACITY-1:0] lev;
  logic [CAPACITY-1:0] le_vec;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [CW-1:0]       mid;
  logic [FCW-1:0]      fold_cnt;
  logic                search_done;

  // chain
  logic [sit_pkg::ID_W-1:0]  cell_id   [CAPACITY];
  logic [TW-1:0]             cell_tail [CAPACITY];
  logic [sit_pkg::REC_W-1:0] cell_rec  [CAPACITY];
  logic [CAPACITY-1:0]       cell_hit;
  logic [LW-1:0]             leaf      [P];
  sit_pkg::cell_cmd_t        cell_cmd;
  sit_pkg::cell_cmd_t        cmd_c;
  logic [IW-1:0]             cmd_pos;

  // hit tree result
  logic [LW-1:0]             fres;
  logic                      fhit;
  logic [IW-1:0]             fidx;
  logic [CW-1:0]             fpos;
  logic [sit_pkg::REC_W-1:0] frec;

  // finish
  logic                       fin_fire;
  logic [sit_pkg::STAT_W-1:0] st_c;
  logic [sit_pkg::REC_W-1:0]  rec_c;
  logic [CW-1:0]              pos_c;
  logic [CW-1:0]              count_next;

  // result register
  logic [sit_pkg::STAT_W-1:0] out_status;
  logic [sit_pkg::REC_W-1:0]  out_rec;
  logic [sit_pkg::POS_W-1:0]  out_pos;
  logic [sit_pkg::POS_W-1:0]  out_cnt;

  // no transaction is taken while reset is held
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign m_axis_tdata  = {{PADW{1'b0}}, out_cnt, out_pos, out_rec};
  assign m_axis_tuser  = out_status;

  // ---------------------------------------------------------------------------
  // Cell chain. Every cell compares itself against the latched key; on an
  // insert or delete the whole tail of the chain moves one slot at once.
  // ---------------------------------------------------------------------------
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [sit_pkg::ID_W-1:0]  lid, rid;
      logic [TW-1:0]             ltl, rtl;
      logic [sit_pkg::REC_W-1:0] lrc, rrc;

      if (i == 0) begin : g_first
        assign lid = '0;
        assign ltl = '0;
        assign lrc = '0;
      end else begin : g_left
        assign lid = cell_id[i-1];
        assign ltl = cell_tail[i-1];
        assign lrc = cell_rec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign rid = '0;
        assign rtl = '0;
        assign rrc = '0;
      end else begin : g_right
        assign rid = cell_id[i+1];
        assign rtl = cell_tail[i+1];
        assign rrc = cell_rec[i+1];
      end

      sit_cell #(
        .INDEX (i),
        .CW    (CW),
        .IW    (IW),
        .TW    (TW)
      ) u_cell (
        .clk        (clk),
        .cmd        (cell_cmd),
        .pos        (cmd_pos),
        .count      (count),
        .ext        (ext),
        .key_id     (key_id_q),
        .key_tail   (key_tail_q),
        .new_rec    (rec_q),
        .left_id    (lid),
        .left_tail  (ltl),
        .left_rec   (lrc),
        .right_id   (rid),
        .right_tail (rtl),
        .right_rec  (rrc),
        .id         (cell_id[i]),
        .tail       (cell_tail[i]),
        .rec        (cell_rec[i]),
        .le         (le_vec[i]),
        .hit        (cell_hit[i])
      );

      // at most one cell hits: full keys are unique, and in id-only mode
      // only the first cell of an equal-id run reports
      assign leaf[i] = cell_hit[i] ? {1'b1, IW'(i), cell_rec[i]} : '0;
    end

    for (i = CAPACITY; i < P; i++) begin : g_pad
      assign leaf[i] = '0;
    end
  endgenerate

  sit_fold #(
    .LEAVES (P),
    .W      (LW)
  ) u_fold (
    .clk    (clk),
    .load   (state == ST_CMP),
    .step   ((state == ST_SEARCH) && (fold_cnt != '0)),
    .leaf   (leaf),
    .result (fres)
  );

  assign fhit = fres[LW-1];
  assign fidx = fres[LW-2 -: IW];
  assign frec = fres[sit_pkg::REC_W-1:0];
  assign fpos = CW'(fidx);

  // ---------------------------------------------------------------------------
  // Upper bound search over the registered le flags: first index whose id
  // is above the key. That is the insertion point for every miss.
  // ---------------------------------------------------------------------------
  assign mid         = lo + ((hi - lo) >> 1);
  assign search_done = (lo == hi) && (fold_cnt == '0);

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && s_axis_tvalid) begin
      op_q       <= s_axis_tuser;
      key_id_q   <= s_axis_tdata[sit_pkg::ID_W-1:0];
      key_tail_q <= s_axis_tdata[sit_pkg::ID_W +: TW];
      rec_q      <= s_axis_tdata[sit_pkg::ID_W + sit_pkg::TAIL_IN_W +: sit_pkg::REC_W];
    end
    if (state == ST_CMP) begin
      lev      <= le_vec;
      lo       <= '0;
      hi       <= count;
      fold_cnt <= FCW'(IW - 1);
    end else if (state == ST_SEARCH) begin
      if (lo != hi) begin
        if (lev[mid[IW-1:0]]) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      if (fold_cnt != '0) begin
        fold_cnt <= fold_cnt - FCW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result and table update, decided in the finish cycle.
  // ---------------------------------------------------------------------------
  assign fin_fire = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    st_c       = sit_pkg::ST_OK;
    rec_c      = '0;
    pos_c      = lo;
    count_next = count;
    cmd_c      = sit_pkg::CMD_HOLD;
    cmd_pos    = lo[IW-1:0];
    case (op_q)
      sit_pkg::OP_ADD: begin
        if (fhit) begin
          st_c  = sit_pkg::ST_DUP;
          pos_c = fpos;
        end else if (count >= CW'(CAPACITY)) begin
          st_c = sit_pkg::ST_FULL;
        end else begin
          cmd_c      = sit_pkg::CMD_INSERT;
          count_next = count + CW'(1);
        end
      end
      sit_pkg::OP_GET: begin
        if (fhit) begin
          rec_c = frec;
          pos_c = fpos;
        end else begin
          st_c = sit_pkg::ST_ABSENT;
        end
      end
      sit_pkg::OP_DEL: begin
        if (fhit) begin
          pos_c      = fpos;
          cmd_c      = sit_pkg::CMD_DELETE;
          cmd_pos    = fidx;
          count_next = count - CW'(1);
        end else begin
          st_c = sit_pkg::ST_ABSENT;
        end
      end
      sit_pkg::OP_FIRST: begin
        pos_c = '0;
        if (count != '0) begin
          rec_c = cell_rec[0];
        end else begin
          st_c = sit_pkg::ST_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

  assign cell_cmd = fin_fire ? cmd_c : sit_pkg::CMD_HOLD;

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_status <= st_c;
      out_rec    <= rec_c;
      out_pos    <= sit_pkg::POS_W'(pos_c);
      out_cnt    <= sit_pkg::POS_W'(count_next);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      count         <= '0;
    end else begin
      // a new result replaces one taken in the same cycle
      if (fin_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (search_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fin_fire) begin
            count <= count_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // extended_key register
  always_ff @(posedge clk) begin
    if (rst) begin
      ext <= 1'b0;
    end else if (cfg_wr_en) begin
      ext <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (cell_cmd == sit_pkg::CMD_INSERT) |-> (count < CW'(CAPACITY)))
    else $error("insert issued into a full table");

  a_delete_hit: assert property (@(posedge clk) disable iff (rst)
    (cell_cmd == sit_pkg::CMD_DELETE) |-> (fhit && (count != '0)))
    else $error("delete issued without a matching entry");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo <= hi))
    else $error("search bounds crossed");

  a_hit_below_ub: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FINISH) && !ext && fhit) |-> (fpos < lo))
    else $error("id-only hit not below the upper bound");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    fin_fire |=> m_axis_tvalid)
    else $error("finished transaction produced no result");

endmodule

`default_nettype wire

// File: tb/tb_sorted_id_table_top.sv
// tb_sorted_id_table_top: self-checking bench for the sorted id table.
// Runs directed and random add/get/delete/get-first traffic against an in-bench table model.
// Depends on sit_pkg and sorted_id_table_top.
`default_nettype none

module tb_sorted_id_table_top;
  import sit_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 500000;

  // one result transaction, field by field
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [REC_W-1:0]  rec;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  cnt;
  } table_result_t;

  // directed row: mode to run in, the input transaction, optional hand-typed result
  typedef struct packed {
    logic              mode;
    logic [OPC_W-1:0]  op;
    logic [ID_W-1:0]   id;
    logic [31:0]       tail;
    logic [REC_W-1:0]  rec;
    logic              typed;
    table_result_t     want;
  } directed_row_t;

  localparam table_result_t PREDICTED = '0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata: key_id [31:0], key_tail [63:32], record_in [95:64]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // tuser: opcode [1:0]
  logic [OPC_W-1:0]      s_axis_tuser = OP_ADD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata: record_out [31:0], position [40:32], entry_count [49:41], zero [55:50]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // tuser: status [1:0]
  logic [STAT_W-1:0]     m_axis_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;

  sorted_id_table_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Table model: sorted ascending by id, equal ids kept in insertion order.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]  tbl_id   [CAP];
  logic [31:0]      tbl_tail [CAP];
  logic [REC_W-1:0] tbl_rec  [CAP];
  int               tbl_count = 0;
  logic             ext_mode  = 1'b0;

  table_result_t pending_results [$];
  int            mismatches = 0;
  int            cycles     = 0;
  int            items_sent = 0;
  bit            calm       = 1'b0;   // both sides run without gaps while set
  int            hold_cnt   = 0;

  // Apply one transaction to the model and return the result it must produce.
  function automatic table_result_t table_apply(input logic [OPC_W-1:0] op,
                                                input logic [ID_W-1:0] id,
                                                input logic [31:0] tail,
                                                input logic [REC_W-1:0] rec);
    table_result_t res;
    int            lo;
    int            i;
    bit            hit;
    res = '0;
    lo  = 0;
    hit = 1'b0;
    if (op == OP_FIRST) begin
      if (tbl_count > 0) res.rec = tbl_rec[0];
      else res.status = ST_ABSENT;
    end else begin
      // lower bound of the id
      while (lo < tbl_count && tbl_id[lo] < id) lo++;
      if (lo < tbl_count && tbl_id[lo] == id) begin
        if (!ext_mode) begin
          hit = 1'b1;
        end else begin
          // walk the run of equal ids for a matching tail; a miss ends past the run
          while (lo < tbl_count && tbl_id[lo] == id && !hit) begin
            if (tbl_tail[lo] == tail) hit = 1'b1;
            else lo++;
          end
        end
      end
      res.pos = lo[POS_W-1:0];
      case (op)
        OP_ADD: begin
          if (hit) begin
            res.status = ST_DUP;
          end else if (tbl_count >= CAP) begin
            res.status = ST_FULL;
          end else begin
            for (i = tbl_count; i > lo; i--) begin
              tbl_id[i]   = tbl_id[i-1];
              tbl_tail[i] = tbl_tail[i-1];
              tbl_rec[i]  = tbl_rec[i-1];
            end
            tbl_id[lo]   = id;
            tbl_tail[lo] = tail;
            tbl_rec[lo]  = rec;
            tbl_count++;
          end
        end
        OP_GET: begin
          if (hit) res.rec = tbl_rec[lo];
          else res.status = ST_ABSENT;
        end
        default: begin
          if (hit) begin
            for (i = lo; i < tbl_count - 1; i++) begin
              tbl_id[i]   = tbl_id[i+1];
              tbl_tail[i] = tbl_tail[i+1];
              tbl_rec[i]  = tbl_rec[i+1];
            end
            tbl_count--;
          end else begin
            res.status = ST_ABSENT;
          end
        end
      endcase
    end
    res.cnt = tbl_count[POS_W-1:0];
    return res;
  endfunction

  // mostly short idles, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Entered and left at a falling edge; valid stays high between
  // back-to-back transactions.
  // ---------------------------------------------------------------------------
  task automatic push_op(input logic [OPC_W-1:0] op, input logic [ID_W-1:0] id,
                         input logic [31:0] tail, input logic [REC_W-1:0] rec,
                         input logic typed, input table_result_t want);
    int            gap;
    table_result_t predicted;
    gap = (calm || $urandom_range(0, 1)) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rec, tail, id};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    // accepted: update the model in acceptance order
    predicted = table_apply(op, id, tail, rec);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    if (items_sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
    @(negedge clk);
  endtask

  // Register write with the block idle: drain results, let it settle, then write.
  task automatic set_mode(input logic mode);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ext_mode = mode;
  endtask

  // Random transaction. Weights are percentages; the remainder goes to get-first.
  // Most non-add keys, a quarter of adds, target live keys: hits, dups and deletes happen often.
  task automatic random_item(input int w_add, input int w_get, input int w_del);
    logic [OPC_W-1:0] op;
    logic [ID_W-1:0]  id;
    logic [31:0]      tail;
    int               idx;
    int               r;
    r    = $urandom_range(0, 99);
    op   = (r < w_add) ? OP_ADD :
           (r < w_add + w_get) ? OP_GET :
           (r < w_add + w_get + w_del) ? OP_DEL : OP_FIRST;
    id   = $urandom;
    tail = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom;
    if (tbl_count > 0 && $urandom_range(0, 99) < ((op == OP_ADD) ? 25 : 85)) begin
      idx  = $urandom_range(0, tbl_count - 1);
      id   = tbl_id[idx];
      tail = tbl_tail[idx];
      // neighbors of a live key; for adds in extended mode this grows equal-id runs
      if (op == OP_ADD || $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0:       id = id + 1;
          1:       id = id - 1;
          2, 3, 4: tail = $urandom_range(0, 3);
          5, 6:    tail = $urandom;
          default: ;
        endcase
      end
    end else if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 5))
        0:       id = 32'h0000_0000;
        1:       id = 32'hFFFF_FFFF;
        2:       id = 32'h8000_0000;
        3:       id = 32'h7FFF_FFFF;
        4:       id = $urandom_range(0, 15);
        default: id = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      endcase
    end
    push_op(op, id, tail, $urandom, 1'b0, PREDICTED);
  endtask

  // ---------------------------------------------------------------------------
  // Directed transactions. Hand-typed results only where obvious; the rest
  // come from the model. Table after row 6: {0, 8000_0000, FFFF_FFFF}.
  // ---------------------------------------------------------------------------
  directed_row_t dir_rows [22] = '{
    // empty table
    '{1'b0, OP_FIRST, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_ABSENT, 32'h0, 9'd0, 9'd0}},
    '{1'b0, OP_GET, 32'h5, 32'h0, 32'h0, 1'b1, '{ST_ABSENT, 32'h0, 9'd0, 9'd0}},
    '{1'b0, OP_DEL, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_ABSENT, 32'h0, 9'd0, 9'd0}},
    // id extremes
    '{1'b0, OP_ADD, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b1,
      '{ST_OK, 32'h0, 9'd0, 9'd1}},
    '{1'b0, OP_ADD, 32'h0, 32'hFFFF_FFFF, 32'h1111_1111, 1'b1,
      '{ST_OK, 32'h0, 9'd0, 9'd2}},
    '{1'b0, OP_ADD, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'h0, 1'b1,
      '{ST_OK, 32'h0, 9'd2, 9'd3}},
    // duplicate: tail ignored with extended keys off
    '{1'b0, OP_ADD, 32'h8000_0000, 32'h1, 32'h22, 1'b1, '{ST_DUP, 32'h0, 9'd1, 9'd3}},
    '{1'b0, OP_GET, 32'h8000_0000, 32'h7, 32'h0, 1'b1,
      '{ST_OK, 32'hFFFF_FFFF, 9'd1, 9'd3}},
    '{1'b0, OP_FIRST, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'h1111_1111, 9'd0, 9'd3}},
    // absent keys report the insertion point
    '{1'b0, OP_GET, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1, '{ST_ABSENT, 32'h0, 9'd1, 9'd3}},
    '{1'b0, OP_DEL, 32'hFFFF_FFFE, 32'h0, 32'h0, 1'b1, '{ST_ABSENT, 32'h0, 9'd2, 9'd3}},
    '{1'b0, OP_DEL, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'h0, 9'd0, 9'd2}},
    '{1'b0, OP_FIRST, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 9'd0, 9'd2}},
    '{1'b0, OP_GET, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'h0, 9'd1, 9'd2}},
    '{1'b0, OP_ADD, 32'h1234_5678, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0, PREDICTED},
    '{1'b0, OP_DEL, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, PREDICTED},
    // extended keys switched on with entries present
    '{1'b1, OP_ADD, 32'h8000_0000, 32'h1, 32'h33, 1'b0, PREDICTED},
    '{1'b1, OP_ADD, 32'h8000_0000, 32'h0, 32'h44, 1'b0, PREDICTED},
    '{1'b1, OP_GET, 32'h8000_0000, 32'h1, 32'h0, 1'b0, PREDICTED},
    '{1'b1, OP_GET, 32'h8000_0000, 32'h2, 32'h0, 1'b0, PREDICTED},
    '{1'b1, OP_DEL, 32'h8000_0000, 32'h0, 32'h0, 1'b0, PREDICTED},
    '{1'b1, OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, PREDICTED}
  };

  // ---------------------------------------------------------------------------
  // Output side: random backpressure, quiet while calm is set.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      hold_cnt = idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker: each transaction against the oldest pending expectation.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, m_axis_tuser);
        check_field("record_out", want.rec, m_axis_tdata[31:0]);
        check_field("position", want.pos, m_axis_tdata[40:32]);
        check_field("entry_count", want.cnt, m_axis_tdata[49:41]);
        check_field("tdata pad", 32'h0, m_axis_tdata[55:50]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sorted_id_table_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].mode != ext_mode) set_mode(dir_rows[k].mode);
      push_op(dir_rows[k].op, dir_rows[k].id, dir_rows[k].tail, dir_rows[k].rec,
              dir_rows[k].typed, dir_rows[k].want);
    end

    // fill to capacity with extended keys, then run mixed traffic, mostly adds, from the full table
    set_mode(1'b1);
    n = 0;
    while (tbl_count < CAP && n < 700) begin
      random_item(92, 4, 2);
      n++;
    end
    repeat (60) random_item(55, 25, 10);

    // plain ids over a table that holds equal-id runs
    set_mode(1'b0);
    repeat (250) random_item(30, 30, 30);

    // drain to empty in extended mode, then poke the empty table
    set_mode(1'b1);
    n = 0;
    while (tbl_count > 0 && n < 700) begin
      random_item(5, 5, 85);
      n++;
    end
    repeat (30) random_item(25, 25, 25);

    set_mode(1'b0);
    repeat (100) random_item(40, 25, 25);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_id_table_top verification clean");
    end else begin
      $display("sorted_id_table_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
